[rtl/dsrs_pkg.sv]
// Shared types, constants and functions of the dual stepper rate sequencer.
package dsrs_pkg;

    localparam int PHASE_COUNT = 8;
    localparam int PH_W        = $clog2(PHASE_COUNT);

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    localparam logic [2:0] ADDR_RPS_MAX = 3'd0;
    localparam logic [2:0] ADDR_STEPS   = 3'd4;

    localparam logic [22:0] RPS_MAX_RST = 23'd19661;
    localparam logic [15:0] STEPS_RST   = 16'd50;

    localparam logic [31:0] IDLE_INTERVAL = 32'd1000000;
    localparam logic [31:0] MAX32         = 32'hFFFF_FFFF;
    localparam logic [47:0] INTERVAL_NUM  = 48'd65536000000;
    localparam logic [23:0] DEADBAND_MAX  = 24'd6;

    localparam int DIV_BITS = 48;
    localparam int CNT_W    = $clog2(DIV_BITS + 1);

    // speed operations run in this order
    localparam logic [1:0] OP_SCALE_L = 2'd0;
    localparam logic [1:0] OP_SCALE_R = 2'd1;
    localparam logic [1:0] OP_INTV_L  = 2'd2;
    localparam logic [1:0] OP_INTV_R  = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [23:0] left_speed;
        logic signed [23:0] right_speed;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         left_coils;
        logic [3:0]         right_coils;
        logic signed [23:0] left_rate;
        logic signed [23:0] right_rate;
        logic               left_stepped;
        logic               right_stepped;
        logic               both_stopped;
    } out_word_t;

    typedef struct packed {
        logic       load;
        logic       exec;
        logic       mul;
        logic       div_start;
        logic       div_step;
        logic       store;
        logic       emit;
        logic [1:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       div_done;
        logic       out_busy;
    } sts_t;

    function automatic logic [3:0] phase_pattern(input logic [PH_W-1:0] ph);
        logic [3:0] pat;
        begin
            case (ph)
                3'd0:    pat = 4'b1000;
                3'd1:    pat = 4'b1010;
                3'd2:    pat = 4'b0010;
                3'd3:    pat = 4'b0110;
                3'd4:    pat = 4'b0100;
                3'd5:    pat = 4'b0101;
                3'd6:    pat = 4'b0001;
                3'd7:    pat = 4'b1001;
                default: pat = 4'b0000;
            endcase
            return pat;
        end
    endfunction

endpackage

[rtl/dsrs_ctrl.sv]
// Controller state machine of the dual stepper rate sequencer.
module dsrs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  dsrs_pkg::sts_t sts,
    output dsrs_pkg::cmd_t cmd
);
    import dsrs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DIVS  = 7'b0001000,
        S_DIVR  = 7'b0010000,
        S_STORE = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_SCALE_L;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.action == ACT_SET)
                begin
                    op_next    = OP_SCALE_L;
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVR;
            end
            S_DIVR:
            begin
                if (sts.div_done)
                    state_next = S_STORE;
                else
                    cmd.div_step = 1'b1;
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (op_reg == OP_INTV_R)
                    state_next = S_EMIT;
                else
                begin
                    op_next    = op_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !sts.out_busy)
        else $error("word emitted while output register is held");

    a_set_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && sts.action == ACT_SET) |=> state_reg == S_MUL)
        else $error("speed update did not enter multiply step");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVR && sts.div_done) |=> state_reg == S_STORE)
        else $error("finished division not stored");

    a_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_STORE && state_reg != S_EXEC) |=> $stable(op_reg))
        else $error("operation index moved outside store");

endmodule

[rtl/dsrs_dp.sv]
// Datapath of the dual stepper rate sequencer: speed shaping, divider, motor timers.
module dsrs_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  dsrs_pkg::cmd_t     cmd,
    output dsrs_pkg::sts_t     sts,
    input  dsrs_pkg::in_word_t in_word,
    input  logic [22:0]        rps_max,
    input  logic [15:0]        steps_per_rev,
    input  logic               out_stall,
    output logic               out_valid,
    output dsrs_pkg::out_word_t out_word
);
    import dsrs_pkg::*;

    typedef struct packed {
        logic [31:0]     intv;
        logic [31:0]     ela;
        logic [PH_W-1:0] ph;
        logic [3:0]      coil;
        logic            step;
    } motor_t;

    function automatic motor_t motor_tick(input logic signed [23:0] spd,
                                          input motor_t m, input logic down);
        motor_t     r;
        logic [31:0] inc;
        begin
            r    = m;
            inc  = (m.ela == MAX32) ? m.ela : m.ela + 32'd1;
            r.ela  = inc;
            r.step = 1'b0;
            if (spd == 24'sd0)
            begin
                r.coil = 4'b0000;
                r.intv = IDLE_INTERVAL;
            end
            else if (inc >= m.intv)
            begin
                r.coil = phase_pattern(m.ph);
                r.ela  = '0;
                r.step = 1'b1;
                r.ph   = down ? m.ph - 1'b1 : m.ph + 1'b1;
            end
            return r;
        end
    endfunction

    logic [1:0]         act_reg;
    logic signed [23:0] lin_reg, rin_reg;
    logic signed [23:0] lspd_reg, rspd_reg;
    logic [23:0]        lmag_reg, rmag_reg;
    motor_t             lm_reg, rm_reg;
    logic [47:0]        prod_reg, quo_reg;
    logic [39:0]        rem_reg, dv_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    out_word_t          out_word_reg;

    logic [23:0] lin_mag, rin_mag, peak, op_mag, shaped;
    logic        need_scale, op_neg;
    logic [40:0] rem_sh;
    logic        q_bit;
    motor_t      lm_tick, rm_tick;

    assign lin_mag    = lin_reg[23] ? 24'(-lin_reg) : 24'(lin_reg);
    assign rin_mag    = rin_reg[23] ? 24'(-rin_reg) : 24'(rin_reg);
    assign peak       = (lin_mag > rin_mag) ? lin_mag : rin_mag;
    assign need_scale = peak > {1'b0, rps_max};

    always_comb
    begin
        case (cmd.op)
            OP_SCALE_L: begin op_mag = lin_mag;  op_neg = lin_reg[23]; end
            OP_SCALE_R: begin op_mag = rin_mag;  op_neg = rin_reg[23]; end
            OP_INTV_L:  begin op_mag = lmag_reg; op_neg = 1'b0;        end
            OP_INTV_R:  begin op_mag = rmag_reg; op_neg = 1'b0;        end
            default:    begin op_mag = lmag_reg; op_neg = 1'b0;        end
        endcase
    end

    // truncate toward zero, then drop tiny speeds
    always_comb
    begin
        shaped = need_scale ? quo_reg[23:0] : op_mag;
        if (shaped <= DEADBAND_MAX)
            shaped = '0;
    end

    assign rem_sh = {rem_reg, quo_reg[DIV_BITS-1]};
    assign q_bit  = rem_sh >= {1'b0, dv_reg};

    assign lm_tick = motor_tick(lspd_reg, lm_reg, lspd_reg < 24'sd0);
    assign rm_tick = motor_tick(rspd_reg, rm_reg, rspd_reg > 24'sd0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= in_word.action;
            lin_reg <= in_word.left_speed;
            rin_reg <= in_word.right_speed;
        end
        if (cmd.mul)
        begin
            if (cmd.op == OP_SCALE_L || cmd.op == OP_SCALE_R)
                prod_reg <= {24'b0, op_mag} * {25'b0, rps_max};
            else
                prod_reg <= {24'b0, op_mag} * {32'b0, steps_per_rev};
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            if (cmd.op == OP_SCALE_L || cmd.op == OP_SCALE_R)
            begin
                quo_reg <= prod_reg;
                dv_reg  <= {16'b0, peak};
            end
            else
            begin
                quo_reg <= INTERVAL_NUM;
                dv_reg  <= prod_reg[39:0];
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? 40'(rem_sh - {1'b0, dv_reg}) : rem_sh[39:0];
            quo_reg <= {quo_reg[DIV_BITS-2:0], q_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            lspd_reg <= '0;
            rspd_reg <= '0;
            lmag_reg <= '0;
            rmag_reg <= '0;
            lm_reg   <= '{intv: IDLE_INTERVAL, ela: '0, ph: '0, coil: '0, step: 1'b0};
            rm_reg   <= '{intv: IDLE_INTERVAL, ela: '0, ph: '0, coil: '0, step: 1'b0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.div_start)
                cnt_reg <= '0;
            else if (cmd.div_step && cnt_reg != CNT_W'(DIV_BITS))
                cnt_reg <= cnt_reg + 1'b1;

            if (cmd.load)
            begin
                lm_reg.step <= 1'b0;
                rm_reg.step <= 1'b0;
            end

            if (cmd.exec)
            begin
                if (act_reg == ACT_TICK)
                begin
                    lm_reg <= lm_tick;
                    rm_reg <= rm_tick;
                end
                else if (act_reg == ACT_STOP)
                begin
                    lspd_reg     <= '0;
                    rspd_reg     <= '0;
                    lm_reg.coil  <= '0;
                    rm_reg.coil  <= '0;
                    lm_reg.intv  <= IDLE_INTERVAL;
                    rm_reg.intv  <= IDLE_INTERVAL;
                end
            end

            if (cmd.store)
            begin
                case (cmd.op)
                    OP_SCALE_L:
                    begin
                        lmag_reg <= shaped;
                        lspd_reg <= op_neg ? 24'(-shaped) : shaped;
                    end
                    OP_SCALE_R:
                    begin
                        rmag_reg <= shaped;
                        rspd_reg <= op_neg ? 24'(-shaped) : shaped;
                    end
                    OP_INTV_L:
                    begin
                        if (lmag_reg == '0)
                            lm_reg.intv <= IDLE_INTERVAL;
                        else if (prod_reg == '0 || quo_reg[47:32] != '0)
                            lm_reg.intv <= MAX32;
                        else
                            lm_reg.intv <= quo_reg[31:0];
                    end
                    OP_INTV_R:
                    begin
                        if (rmag_reg == '0)
                            rm_reg.intv <= IDLE_INTERVAL;
                        else if (prod_reg == '0 || quo_reg[47:32] != '0)
                            rm_reg.intv <= MAX32;
                        else
                            rm_reg.intv <= quo_reg[31:0];
                    end
                    default: ;
                endcase
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_word_reg.left_coils    <= lm_reg.coil;
            out_word_reg.right_coils   <= rm_reg.coil;
            out_word_reg.left_rate     <= lspd_reg;
            out_word_reg.right_rate    <= rspd_reg;
            out_word_reg.left_stepped  <= lm_reg.step;
            out_word_reg.right_stepped <= rm_reg.step;
            out_word_reg.both_stopped  <= (lspd_reg == '0) && (rspd_reg == '0);
        end
    end

    assign sts.action   = act_reg;
    assign sts.div_done = (cnt_reg == CNT_W'(DIV_BITS));
    assign sts.out_busy = out_valid_reg && out_stall;
    assign out_valid    = out_valid_reg;
    assign out_word     = out_word_reg;

endmodule

[rtl/dual_stepper_rate_sequencer.sv]
// Top level of the dual stepper rate sequencer: configuration registers and wiring.
//
// Drives two 4-coil steppers through the 8-phase half-step sequence and returns one
// word per input word. A tick or stop word passes through the execute and emit states
// before its result is offered; a set-speeds word goes through one shared radix-2
// divider that runs 48 iterations for each of four divisions (two speed scalings, two
// step intervals), each preceded by a multiply. A new word is taken only after the
// previous result is loaded into the output register. rps_max lies at address 0 and
// steps_per_rev at address 4; write them only while the block is idle.
module dual_stepper_rate_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dsrs_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output dsrs_pkg::out_word_t out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import dsrs_pkg::*;

    logic [22:0] rps_max_reg;
    logic [15:0] steps_reg;
    cmd_t        cmd;
    sts_t        sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rps_max_reg <= RPS_MAX_RST;
            steps_reg   <= STEPS_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                ADDR_RPS_MAX: rps_max_reg <= pwdata[22:0];
                ADDR_STEPS:   steps_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_RPS_MAX: prdata = {9'b0, rps_max_reg};
            ADDR_STEPS:   prdata = {16'b0, steps_reg};
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    dsrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dsrs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_word       (in_word),
        .rps_max       (rps_max_reg),
        .steps_per_rev (steps_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_word      (out_word)
    );

endmodule

[tb/tb_dual_stepper_rate_sequencer.sv]
// Self-checking testbench for the dual stepper rate sequencer: directed table, then random words.
module tb_dual_stepper_rate_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import dsrs_pkg::*;

    localparam int IDLE_LIMIT    = 20000;
    localparam int N_RANDOM      = 500;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [3:0] COIL_SEQ [8] = '{4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9};
    localparam logic [1:0] ACT_NONE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dual_stepper_rate_sequencer dut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Motor model: index 0 is left, 1 is right
    logic [22:0]        cur_rps_max;
    logic [15:0]        cur_steps;
    logic signed [23:0] speed_now [2];
    logic [31:0]        interval  [2];
    logic [31:0]        elapsed   [2];
    logic [2:0]         phase     [2];
    logic [3:0]         coils     [2];

    out_word_t expected_words [$];
    int errors;
    int reports;
    int n_ticks, n_sets, n_steps, n_results;
    int idle_cycles;

    function automatic logic [31:0] step_interval(longint unsigned mag);
        longint unsigned den;
        longint unsigned q;
        if (mag == 0)
            return IDLE_INTERVAL;
        den = mag * cur_steps;
        if (den == 0)
            return MAX32;
        q = 64'd65536000000 / den;
        return (q > 64'hFFFF_FFFF) ? MAX32 : q[31:0];
    endfunction

    function automatic longint unsigned magnitude(logic signed [23:0] v);
        longint s;
        s = v;
        return (s < 0) ? -s : s;
    endfunction

    function automatic logic signed [23:0] limit_speed(logic signed [23:0] v,
                                                       longint unsigned peak);
        longint unsigned m;
        longint s;
        m = magnitude(v);
        if (peak > cur_rps_max)
            m = (m * cur_rps_max) / peak;
        if (m <= 6)
            return '0;
        s = (v < 0) ? -longint'(m) : longint'(m);
        return s[23:0];
    endfunction

    function automatic logic run_motor(int i, logic down);
        if (elapsed[i] != MAX32)
            elapsed[i]++;
        if (speed_now[i] == 0)
        begin
            coils[i] = '0;
            interval[i] = IDLE_INTERVAL;
            return 1'b0;
        end
        if (elapsed[i] >= interval[i])
        begin
            coils[i] = COIL_SEQ[phase[i]];
            elapsed[i] = '0;
            phase[i] = down ? phase[i] - 3'd1 : phase[i] + 3'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic out_word_t advance_motors(in_word_t w);
        out_word_t r;
        longint unsigned peak;
        r = '0;
        case (w.action)
            ACT_SET:
            begin
                peak = magnitude(w.left_speed);
                if (magnitude(w.right_speed) > peak)
                    peak = magnitude(w.right_speed);
                speed_now[0] = limit_speed(w.left_speed, peak);
                speed_now[1] = limit_speed(w.right_speed, peak);
                interval[0] = step_interval(magnitude(speed_now[0]));
                interval[1] = step_interval(magnitude(speed_now[1]));
            end
            ACT_TICK:
            begin
                r.left_stepped  = run_motor(0, speed_now[0] < 0);
                r.right_stepped = run_motor(1, speed_now[1] > 0);
            end
            ACT_STOP:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    coils[i] = '0;
                    speed_now[i] = '0;
                    interval[i] = IDLE_INTERVAL;
                end
            end
            default: ;
        endcase
        r.left_coils   = coils[0];
        r.right_coils  = coils[1];
        r.left_rate    = speed_now[0];
        r.right_rate   = speed_now[1];
        r.both_stopped = (speed_now[0] == 0) && (speed_now[1] == 0);
        return r;
    endfunction

    // Send one word; the caller decides whether valid drops afterwards
    task automatic send_word(in_word_t w, logic use_typed, out_word_t typed);
        out_word_t pred;
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        pred = advance_motors(w);
        expected_words.push_back(use_typed ? typed : pred);
        if (w.action == ACT_TICK)
            n_ticks++;
        if (w.action == ACT_SET)
            n_sets++;
    endtask

    task automatic drop_valid(int gap);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    task automatic drain;
        if (in_valid)
            drop_valid(0);
        wait (expected_words.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RPS_MAX)
            cur_rps_max = data[22:0];
        else
            cur_steps = data[15:0];
    endtask

    function automatic logic signed [23:0] pick_speed();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return 24'($urandom());
        if (sel < 70)
            return $urandom_range(0, 1) ? 24'($urandom_range(1 << 20, 8388607))
                                        : -24'($urandom_range(1 << 20, 8388607));
        if (sel < 90)
            return 24'(int'($urandom_range(0, 40)) - 20);
        case ($urandom_range(0, 3))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return 24'sd7;
            default: return -24'sd7;
        endcase
    endfunction

    task automatic random_words(int count);
        in_word_t w;
        int burst;
        int sel;
        burst = $urandom_range(1, 20);
        for (int k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            w.action      = (sel < 70) ? ACT_TICK : (sel < 88) ? ACT_SET :
                            (sel < 95) ? ACT_STOP : ACT_NONE;
            w.left_speed  = pick_speed();
            w.right_speed = pick_speed();
            send_word(w, 1'b0, '0);
            if (--burst == 0)
            begin
                drop_valid($urandom_range(0, 6));
                burst = $urandom_range(1, 20);
            end
        end
    endtask

    typedef struct {
        in_word_t  word;
        logic      typed;
        out_word_t result;
    } stim_row_t;

    localparam out_word_t ALL_IDLE = '{default: '0, both_stopped: 1'b1};

    stim_row_t directed [] = '{
        '{'{ACT_TICK, 24'sd0, 24'sd0}, 1'b1, ALL_IDLE},
        '{'{ACT_NONE, 24'sh7FFFFF, 24'sh800000}, 1'b1, ALL_IDLE},
        '{'{ACT_SET, 24'sh7FFFFF, 24'sh800000}, 1'b0, '0},
        '{'{ACT_TICK, 24'sh800000, 24'sh7FFFFF}, 1'b0, '0},
        '{'{ACT_NONE, 24'sd0, 24'sd0}, 1'b0, '0},
        '{'{ACT_STOP, 24'sh7FFFFF, 24'sh7FFFFF}, 1'b1, ALL_IDLE},
        '{'{ACT_SET, 24'sd6, -24'sd6}, 1'b1, ALL_IDLE},
        '{'{ACT_SET, 24'sd7, -24'sd7}, 1'b0, '0},
        '{'{ACT_TICK, 24'sd0, 24'sd0}, 1'b0, '0},
        '{'{ACT_SET, 24'sd19661, -24'sd100}, 1'b0, '0},
        '{'{ACT_TICK, 24'sd0, 24'sd0}, 1'b0, '0},
        '{'{ACT_SET, 24'sd0, 24'sh800000}, 1'b0, '0},
        '{'{ACT_TICK, 24'sd0, 24'sd0}, 1'b0, '0},
        '{'{ACT_SET, 24'sh555555, 24'shAAAAAA}, 1'b0, '0},
        '{'{ACT_STOP, 24'sd0, 24'sd0}, 1'b1, ALL_IDLE}
    };

    // Receiver stall pattern: mode changes when its randomly drawn age runs out
    int stall_mode;
    int stall_age;
    always @(negedge clk)
    begin
        if (stall_age == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_age  <= $urandom_range(50, 300);
        end
        else
            stall_age <= stall_age - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            default: out_stall <= (stall_age % 16) < 5;
        endcase
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (reports++ < MAX_REPORTS)
                    $display("unexpected result word %h", out_word);
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_word.left_coils !== want.left_coils
                    || out_word.right_coils !== want.right_coils
                    || out_word.left_rate !== want.left_rate
                    || out_word.right_rate !== want.right_rate
                    || out_word.left_stepped !== want.left_stepped
                    || out_word.right_stepped !== want.right_stepped
                    || out_word.both_stopped !== want.both_stopped)
                begin
                    errors++;
                    if (reports++ < MAX_REPORTS)
                        $display("result %0d mismatch: expected %p got %p",
                                 n_results, want, out_word);
                end
                n_steps += want.left_stepped + want.right_stepped;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL dual_stepper_rate_sequencer");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_mode = 0;
        stall_age = 0;
        errors = 0;
        reports = 0;
        n_ticks = 0;
        n_sets = 0;
        n_steps = 0;
        n_results = 0;
        idle_cycles = 0;
        cur_rps_max = RPS_MAX_RST;
        cur_steps = STEPS_RST;
        for (int i = 0; i < 2; i++)
        begin
            speed_now[i] = '0;
            interval[i] = IDLE_INTERVAL;
            elapsed[i] = '0;
            phase[i] = '0;
            coils[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            send_word(directed[i].word, directed[i].typed, directed[i].result);
            if ($urandom_range(0, 3) == 0)
                drop_valid($urandom_range(0, 3));
        end
        random_words(40);
        drain();

        // Fast stepping: large speeds step on nearly every tick
        write_reg(ADDR_RPS_MAX, 32'h007F_FFFF);
        write_reg(ADDR_STEPS, 32'h0000_FFFF);
        random_words(N_RANDOM / 5);
        // Hold off until the block has delivered everything
        drain();
        random_words(N_RANDOM / 10);
        drain();

        // Zero speed limit, which scales every nonzero speed to zero, with a single step per revolution
        write_reg(ADDR_RPS_MAX, 32'h0);
        write_reg(ADDR_STEPS, 32'h1);
        random_words(N_RANDOM / 10);
        drain();

        write_reg(ADDR_RPS_MAX, 32'd500000);
        write_reg(ADDR_STEPS, 32'h0);
        random_words(N_RANDOM / 10);
        drain();

        write_reg(ADDR_RPS_MAX, 32'h007F_FFFF);
        write_reg(ADDR_STEPS, 32'd3000);
        random_words(N_RANDOM / 5);
        drain();

        write_reg(ADDR_RPS_MAX, 32'd2000000);
        write_reg(ADDR_STEPS, 32'd200);
        random_words(N_RANDOM / 5);
        drain();

        $display("covered %0d ticks and %0d speed updates across six register settings",
                 n_ticks, n_sets);
        $display("%0d results checked, %0d motor steps, %0d mismatches",
                 n_results, n_steps, errors);
        if (errors == 0 && expected_words.size() == 0)
            $display("PASS dual_stepper_rate_sequencer");
        else
            $display("FAIL dual_stepper_rate_sequencer");
        $finish;
    end
endmodule
